// File: rtl/core/rewm_pkg.sv
// Shared types and constants for the recent event window match block.
// No dependencies; every other file takes names from here by scope.
package rewm_pkg;

   localparam int unsigned ENTRIES = 16;
   localparam int unsigned IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   localparam logic [15:0] POSITION_LIMIT = 16'd64;

   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam int unsigned CSR_IDX_W = 8;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_TARGET_LIMIT = 8'd0;
   localparam csr_index_type CSR_WINDOW = 8'd1;

   localparam logic [15:0] TARGET_LIMIT_RESET = 16'hFFFF;
   localparam logic [31:0] WINDOW_RESET = 32'd1000;

   typedef enum logic [1:0] {
      CMD_REJECT,
      CMD_RECORD,
      CMD_QUERY
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [63:0]  context_tag;
      logic [63:0]  block_tag;
      logic [31:0]  item_id;
      logic [15:0]  target_position;
      logic [31:0]  now_ms;
   } cmd_type;

   typedef struct packed {
      logic [63:0] context_tag;
      logic [63:0] block_tag;
      logic [31:0] item_id;
      logic [15:0] target_position;
      logic [31:0] stamp;
   } entry_type;

   typedef struct packed {
      logic        accepted;
      logic        found;
      logic [31:0] age_ms;
   } resp_type;

   typedef struct packed {
      logic scanning;
      logic popping;
   } back_stat_type;

endpackage

// File: rtl/core/rewm_if.sv
// Request, response and register write channels of the block.
// Depends on rewm_pkg for the register index width.
interface rewm_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [63:0] context_tag;
   logic [63:0] block_tag;
   logic [31:0] item_id;
   logic [15:0] position_index;
   logic [15:0] target_position;
   logic [31:0] now_ms;

   modport source (output valid, operation, context_tag, block_tag, item_id,
      position_index, target_position, now_ms, input ready);
   modport sink (input valid, operation, context_tag, block_tag, item_id,
      position_index, target_position, now_ms, output ready);
endinterface

interface rewm_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic        found;
   logic [31:0] age_ms;

   modport source (output valid, accepted, found, age_ms, input ready);
   modport sink (input valid, accepted, found, age_ms, output ready);
endinterface

interface rewm_csr_if;
   logic                         valid;
   logic                         ready;
   rewm_pkg::csr_index_type      index;
   logic [31:0]                  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/rewm_front.sv
// Front end: takes requests and classifies them as record, query or reject.
// Depends on rewm_pkg and the request channel interface.
module rewm_front (
   rewm_req_if.sink          req_bus,
   input  logic [15:0]       target_limit,
   output logic              push_valid,
   input  logic              push_ready,
   output rewm_pkg::cmd_type push_cmd
);

   logic key_ok;

   always_comb begin
      key_ok = (req_bus.block_tag != 64'd0) && (req_bus.item_id != 32'd0) &&
               (req_bus.target_position <= target_limit);
      push_cmd.context_tag = req_bus.context_tag;
      push_cmd.block_tag = req_bus.block_tag;
      push_cmd.item_id = req_bus.item_id;
      push_cmd.target_position = req_bus.target_position;
      push_cmd.now_ms = req_bus.now_ms;
      if (!key_ok) begin
         push_cmd.kind = rewm_pkg::CMD_REJECT;
      end else if (req_bus.operation == rewm_pkg::OP_QUERY) begin
         push_cmd.kind = rewm_pkg::CMD_QUERY;
      end else if (req_bus.position_index >= rewm_pkg::POSITION_LIMIT) begin
         push_cmd.kind = rewm_pkg::CMD_REJECT;
      end else begin
         push_cmd.kind = rewm_pkg::CMD_RECORD;
      end
   end

   assign push_valid = req_bus.valid;
   assign req_bus.ready = push_ready;

endmodule

// File: rtl/core/rewm_queue.sv
// Two-slot command queue between front end and back end.
// Depends on rewm_pkg for the command type.
module rewm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  rewm_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop_take,
   output rewm_pkg::cmd_type pop_cmd
);

   rewm_pkg::cmd_type slot_ff [2];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        count_ff;
   logic              push_fire;
   logic              pop_fire;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_cmd = slot_ff[rd_ptr_ff];
   assign push_fire = push_valid && push_ready;
   assign pop_fire = pop_take && pop_valid;

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push_fire) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop_fire) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         case ({push_fire, pop_fire})
            2'b10: count_ff <= count_ff + 2'd1;
            2'b01: count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// File: rtl/core/rewm_back.sv
// Back end: event ring, record writes, one-entry-per-cycle query scan and
// the response register. Depends on rewm_pkg and the response interface.
module rewm_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [31:0]             window_ms,
   input  logic                    pop_valid,
   output logic                    pop_take,
   input  rewm_pkg::cmd_type       pop_cmd,
   rewm_rsp_if.source              rsp_bus,
   output rewm_pkg::back_stat_type stat
);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type                   state_ff;
   rewm_pkg::entry_type         mem [rewm_pkg::ENTRIES];
   rewm_pkg::entry_type         rd_ff;
   rewm_pkg::entry_type         wr_entry;
   logic [rewm_pkg::ENTRIES-1:0] live_ff;
   logic                        rdv_ff;
   logic [rewm_pkg::IDX_W-1:0]  wp_ff;
   logic [rewm_pkg::IDX_W-1:0]  wp_in;
   logic [rewm_pkg::IDX_W-1:0]  issue_ff;
   logic                        issuing_ff;
   logic                        chk_ff;
   logic                        chk_last_ff;
   rewm_pkg::cmd_type           key_ff;
   logic                        out_valid_ff;
   rewm_pkg::resp_type          out_ff;
   logic                        out_free;
   logic                        pop;
   logic                        mem_we;
   logic                        ctx_ok;
   logic                        hit;
   logic                        scan_done;
   logic [31:0]                 age;

   always_comb begin
      out_free = !out_valid_ff || rsp_bus.ready;
      pop = (state_ff == ST_IDLE) && pop_valid && out_free;
      mem_we = pop && (pop_cmd.kind == rewm_pkg::CMD_RECORD);
      wp_in = (wp_ff == rewm_pkg::LAST_IDX) ? '0 : wp_ff + 1'b1;
      wr_entry.context_tag = pop_cmd.context_tag;
      wr_entry.block_tag = pop_cmd.block_tag;
      wr_entry.item_id = pop_cmd.item_id;
      wr_entry.target_position = pop_cmd.target_position;
      wr_entry.stamp = pop_cmd.now_ms;
      age = key_ff.now_ms - rd_ff.stamp;
      ctx_ok = (rd_ff.context_tag == 64'd0) || (key_ff.context_tag == 64'd0) ||
               (rd_ff.context_tag == key_ff.context_tag);
      hit = rdv_ff && (rd_ff.item_id == key_ff.item_id) &&
            (rd_ff.block_tag == key_ff.block_tag) &&
            (rd_ff.target_position == key_ff.target_position) &&
            ctx_ok && (age <= window_ms);
      scan_done = (state_ff == ST_SCAN) && chk_ff && (hit || chk_last_ff);
   end

   assign pop_take = pop;
   assign stat.scanning = (state_ff == ST_SCAN);
   assign stat.popping = pop;

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.accepted = out_ff.accepted;
   assign rsp_bus.found = out_ff.found;
   assign rsp_bus.age_ms = out_ff.age_ms;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wp_ff] <= wr_entry;
      end
      rd_ff <= mem[issue_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wp_ff <= '0;
         live_ff <= '0;
         issuing_ff <= 1'b0;
         chk_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  unique case (pop_cmd.kind)
                     rewm_pkg::CMD_RECORD: begin
                        live_ff[wp_ff] <= 1'b1;
                        wp_ff <= wp_in;
                        out_valid_ff <= 1'b1;
                        out_ff <= '{accepted: 1'b1, found: 1'b0, age_ms: 32'd0};
                     end
                     rewm_pkg::CMD_QUERY: begin
                        key_ff <= pop_cmd;
                        issue_ff <= '0;
                        issuing_ff <= 1'b1;
                        out_valid_ff <= 1'b0;
                        state_ff <= ST_SCAN;
                     end
                     default: begin
                        out_valid_ff <= 1'b1;
                        out_ff <= '{accepted: 1'b0, found: 1'b0, age_ms: 32'd0};
                     end
                  endcase
               end else if (rsp_bus.ready) begin
                  out_valid_ff <= 1'b0;
               end
            end
            ST_SCAN: begin
               if (scan_done) begin
                  out_valid_ff <= 1'b1;
                  out_ff <= '{accepted: 1'b1, found: hit, age_ms: hit ? age : 32'd0};
                  issuing_ff <= 1'b0;
                  chk_ff <= 1'b0;
                  state_ff <= ST_IDLE;
               end else begin
                  chk_ff <= issuing_ff;
                  if (issuing_ff) begin
                     rdv_ff <= live_ff[issue_ff];
                     chk_last_ff <= (issue_ff == rewm_pkg::LAST_IDX);
                     issue_ff <= issue_ff + 1'b1;
                     issuing_ff <= (issue_ff != rewm_pkg::LAST_IDX);
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// File: rtl/core/recent_event_window_match.sv
// Recent event window match: a ring of ENTRIES (16) recent events that
// record requests overwrite oldest first and query requests search for the
// first live entry matching item, block, target and context within the age
// window. Record and rejected requests are answered through the response
// register without leaving the idle state; a query holds the back end in
// the scan state until an entry matches or the last entry is checked, set by
// the single read port of the event ring scanned one entry a cycle.
// A two-slot queue lets new requests in while a query scans and while a
// response waits. Register writes are taken every cycle.
module recent_event_window_match (
   input  logic       clock,
   input  logic       reset,
   rewm_req_if.sink   req_bus,
   rewm_rsp_if.source rsp_bus,
   rewm_csr_if.sink   csr_bus
);

   logic [15:0]             target_limit_ff;
   logic [31:0]             window_ff;
   logic                    push_valid;
   logic                    push_ready;
   rewm_pkg::cmd_type       push_cmd;
   logic                    pop_valid;
   logic                    pop_take;
   rewm_pkg::cmd_type       pop_cmd;
   rewm_pkg::back_stat_type stat;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_limit_ff <= rewm_pkg::TARGET_LIMIT_RESET;
         window_ff <= rewm_pkg::WINDOW_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            rewm_pkg::CSR_TARGET_LIMIT: target_limit_ff <= csr_bus.data[15:0];
            rewm_pkg::CSR_WINDOW: window_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   rewm_front u_front (
      .req_bus      (req_bus),
      .target_limit (target_limit_ff),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_cmd     (push_cmd)
   );

   rewm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_take   (pop_take),
      .pop_cmd    (pop_cmd)
   );

   rewm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .window_ms (window_ff),
      .pop_valid (pop_valid),
      .pop_take  (pop_take),
      .pop_cmd   (pop_cmd),
      .rsp_bus   (rsp_bus),
      .stat      (stat)
   );

   a_no_rsp_while_scanning: assert property (@(posedge clock) disable iff (reset)
      stat.scanning |-> !rsp_bus.valid)
      else $error("response shown during a scan");

   a_rsp_has_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> ($past(stat.popping) || $past(stat.scanning)))
      else $error("response without a command behind it");

   a_window_write: assert property (@(posedge clock) disable iff (reset)
      (csr_bus.valid && csr_bus.ready && csr_bus.index == rewm_pkg::CSR_WINDOW)
      |=> (window_ff == $past(csr_bus.data)))
      else $error("window register lost a write");

endmodule
